// ----- rtl/smcw_pkg.sv -----
// ----------------------------------------------------------------------------
// smcw_pkg: shared types and constants for the motor command watchdog
// Holds the job record passed from the front end to the back end.
// ----------------------------------------------------------------------------
package smcw_pkg;

  localparam int unsigned FrameDepthDef = 16;
  localparam logic [15:0] TimeoutRst    = 16'd500;
  localparam logic [15:0] CenterRst     = 16'd155;
  localparam logic [7:0]  MinDriveRst   = 8'd100;

  localparam logic [7:0] ChBang  = 8'h21;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChEq    = 8'h3D;
  localparam logic [7:0] ChM     = 8'h4D;
  localparam logic [7:0] ChR     = 8'h52;
  localparam logic [7:0] ChL     = 8'h4C;
  localparam logic [7:0] ChW     = 8'h57;
  localparam logic [7:0] ChD     = 8'h44;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  localparam logic [1:0] DirStop = 2'd0;
  localparam logic [1:0] DirFwd  = 2'd1;
  localparam logic [1:0] DirRev  = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [1:0] RegTimeout  = 2'd0;
  localparam logic [1:0] RegCenter   = 2'd1;
  localparam logic [1:0] RegMinDrive = 2'd2;

  typedef enum logic [2:0] {
    JobByte, JobTick, JobBad, JobMr, JobMl, JobWd
  } job_kind_e;

  typedef struct packed {
    job_kind_e kind;
  } job_t;

  // Tail bytes of the replies.
  function automatic logic [7:0] ok_tail(input logic [1:0] i);
    logic [7:0] c;
    case (i)
      2'd0:    c = 8'h20;
      2'd1:    c = 8'h4F;
      2'd2:    c = 8'h4B;
      default: c = 8'h0A;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] nok_tail(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0:    c = 8'h20;
      3'd1:    c = 8'h4E;
      3'd2:    c = 8'h4F;
      3'd3:    c = 8'h4B;
      default: c = 8'h0A;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/smcw_front.sv -----
// ----------------------------------------------------------------------------
// smcw_front: frame collection and classification
// Stores received bytes and turns each input word into a job for the back end.
// ----------------------------------------------------------------------------
module smcw_front import smcw_pkg::*; #(
  parameter int unsigned FrameDepth = FrameDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       cmd_i,
  input  logic [7:0] rx_byte_i,
  output logic       job_valid_o,
  input  logic       job_ready_i,
  output job_t       job_o,
  input  logic       busy_i,
  output logic [FrameDepth*8-1:0] frame_o
);
  localparam int unsigned IdxW  = $clog2(FrameDepth + 1);
  localparam int unsigned AddrW = $clog2(FrameDepth);

  logic [7:0]      buf_q [FrameDepth];
  logic [IdxW-1:0] idx_q;
  logic            full;
  job_t            job;
  logic            acc;

  // The buffer must not change while the back end reads it for a frame.
  assign in_ready_o  = job_ready_i && !busy_i;
  assign job_valid_o = in_valid_i && !busy_i;
  assign acc         = in_valid_i && in_ready_o;
  assign full        = (idx_q == IdxW'(FrameDepth));

  // A terminator that lands inside the command header, with fewer than four
  // bytes stored, always makes the frame bad, whatever the buffer holds.
  always_comb begin
    job.kind = JobByte;
    if (cmd_i) begin
      job.kind = JobTick;
    end else if (rx_byte_i == ChBang) begin
      if (idx_q < IdxW'(4)) job.kind = JobBad;
      else if (buf_q[0] != ChColon) job.kind = JobBad;
      else if (buf_q[1] == ChM && buf_q[2] == ChR && buf_q[3] == ChEq) job.kind = JobMr;
      else if (buf_q[1] == ChM && buf_q[2] == ChL && buf_q[3] == ChEq) job.kind = JobMl;
      else if (buf_q[1] == ChW && buf_q[2] == ChD && buf_q[3] == ChEq) job.kind = JobWd;
      else job.kind = JobBad;
    end
  end
  assign job_o = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      for (int i = 0; i < FrameDepth; i++) buf_q[i] <= '0;
    end else if (acc && !cmd_i) begin
      if (!full) buf_q[idx_q[AddrW-1:0]] <= rx_byte_i;
      if (rx_byte_i == ChBang) idx_q <= '0;
      else if (!full) idx_q <= idx_q + 1'b1;
    end
  end

  // The terminator is stored this edge unless the buffer is full; the back end
  // reads the buffer from the next cycle on, so it sees a stored one in place.
  for (genvar g = 0; g < FrameDepth; g++) begin : g_out
    assign frame_o[g*8 +: 8] = buf_q[g];
  end
endmodule

// ----- rtl/smcw_queue.sv -----
// ----------------------------------------------------------------------------
// smcw_queue: two-entry job queue
// Decouples the classifying front end from the executing back end.
// ----------------------------------------------------------------------------
module smcw_queue import smcw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  job_t wr_job_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output job_t rd_job_o,
  output logic empty_o
);
  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign empty_o    = (cnt_q == 2'd0);
  assign rd_job_o   = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_job_i;
  end
endmodule

// ----- rtl/smcw_back.sv -----
// ----------------------------------------------------------------------------
// smcw_back: command execution and reply generation
// Parses numbers, drives the motors, runs the watchdog and streams replies.
// ----------------------------------------------------------------------------
module smcw_back import smcw_pkg::*; #(
  parameter int unsigned FrameDepth = FrameDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        job_valid_i,
  output logic        job_ready_o,
  input  job_t        job_i,
  input  logic [FrameDepth*8-1:0] frame_i,
  input  logic [15:0] timeout_i,
  input  logic [15:0] center_i,
  input  logic [7:0]  min_drive_i,
  output logic        busy_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        is_reply_o,
  output logic [7:0]  reply_byte_o,
  output logic [1:0]  right_dir_o,
  output logic [7:0]  right_pwm_o,
  output logic [1:0]  left_dir_o,
  output logic [7:0]  left_pwm_o,
  output logic        link_alive_o,
  output logic        last_o
);
  localparam int unsigned PosW  = $clog2(FrameDepth + 1);
  localparam int unsigned AddrW = $clog2(FrameDepth);

  typedef enum logic [2:0] {
    StIdle, StSkip, StSign, StDigit, StApply, StWatch, StReply, StStatus
  } state_e;

  state_e        st_q;
  job_kind_e     kind_q;
  logic [PosW-1:0] pos_q;
  logic          neg_q;
  logic [31:0]   acc_q;
  logic [31:0]   wd_val_q, wd_seen_q;
  logic          alive_q;
  logic [15:0]   quiet_q;
  logic [1:0]    rdir_q, ldir_q;
  logic [7:0]    rpwm_q, lpwm_q;
  logic [3:0]    rcnt_q;
  logic          ovalid_q, oreply_q, olast_q;
  logic [7:0]    obyte_q;
  logic [1:0]    ordir_q, oldir_q;
  logic [7:0]    orpwm_q, olpwm_q;
  logic          oalive_q;

  logic [7:0]  ch;
  logic        at_end, is_ws, is_dig;
  logic [31:0] num, v, mag;
  logic [8:0]  sum;
  logic [7:0]  pwm_new;
  logic [7:0]  rep_byte;
  logic        out_free;
  logic        emit;

  assign at_end = (pos_q >= PosW'(FrameDepth));
  assign ch     = at_end ? 8'h00 : frame_i[pos_q[AddrW-1:0]*8 +: 8];
  assign is_ws  = (ch == ChSpace) || (ch >= 8'd9 && ch <= 8'd13);
  assign is_dig = (ch >= ChZero) && (ch <= ChNine);
  assign num    = neg_q ? (32'd0 - acc_q) : acc_q;
  assign v      = num - {16'd0, center_i};
  assign mag    = v[31] ? (32'd0 - v) : v;
  assign sum    = {1'b0, mag[7:0]} + {1'b0, min_drive_i};
  assign pwm_new = (|mag[31:8] || sum[8]) ? 8'hFF : sum[7:0];

  // Reply sequence: OK is buffer bytes 1..6 and four tail bytes, NOK is
  // bytes 0..9 and five tail bytes.
  always_comb begin
    if (kind_q == JobBad) begin
      if (rcnt_q < 4'd10) rep_byte = frame_i[rcnt_q*8 +: 8];
      else rep_byte = nok_tail(3'(rcnt_q - 4'd10));
    end else begin
      if (rcnt_q < 4'd6) rep_byte = frame_i[(rcnt_q + 4'd1)*8 +: 8];
      else rep_byte = ok_tail(2'(rcnt_q - 4'd6));
    end
  end

  assign out_free    = !ovalid_q || out_ready_i;
  assign emit        = out_free && (st_q == StReply || st_q == StStatus);
  assign job_ready_o = (st_q == StIdle);
  assign busy_o      = (st_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; kind_q <= JobByte; pos_q <= '0; neg_q <= 1'b0;
      acc_q <= '0; wd_val_q <= '0; wd_seen_q <= '0; alive_q <= 1'b0;
      quiet_q <= '0; rdir_q <= DirStop; ldir_q <= DirStop;
      rpwm_q <= '0; lpwm_q <= '0; rcnt_q <= '0;
      ovalid_q <= 1'b0; oreply_q <= 1'b0; olast_q <= 1'b0; obyte_q <= '0;
      ordir_q <= DirStop; oldir_q <= DirStop; orpwm_q <= '0; olpwm_q <= '0;
      oalive_q <= 1'b0;
    end else begin
      // The output word holds a copy of the motor and link state, so a job
      // that starts while it waits cannot change it.
      if (emit) begin
        ovalid_q <= 1'b1;
        ordir_q  <= rdir_q; orpwm_q <= rpwm_q;
        oldir_q  <= ldir_q; olpwm_q <= lpwm_q;
        oalive_q <= alive_q;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
      case (st_q)
        StIdle: begin
          if (job_valid_i) begin
            kind_q <= job_i.kind;
            pos_q <= PosW'(4); neg_q <= 1'b0; acc_q <= '0; rcnt_q <= '0;
            case (job_i.kind)
              JobMr, JobMl, JobWd: st_q <= StSkip;
              JobTick: begin
                if (quiet_q != 16'hFFFF) quiet_q <= quiet_q + 16'd1;
                st_q <= StWatch;
              end
              default: st_q <= StWatch;
            endcase
          end
        end
        StSkip: begin
          if (!at_end && is_ws) pos_q <= pos_q + 1'b1;
          else st_q <= StSign;
        end
        StSign: begin
          if (!at_end && (ch == ChPlus || ch == ChMinus)) begin
            neg_q <= (ch == ChMinus);
            pos_q <= pos_q + 1'b1;
          end
          st_q <= StDigit;
        end
        StDigit: begin
          if (!at_end && is_dig) begin
            acc_q <= (acc_q << 3) + (acc_q << 1) + {24'd0, ch - ChZero};
            pos_q <= pos_q + 1'b1;
          end else begin
            st_q <= StApply;
          end
        end
        StApply: begin
          if (kind_q == JobWd) begin
            wd_val_q <= num;
          end else if (v == 32'd0) begin
            if (kind_q == JobMr) begin rdir_q <= DirStop; rpwm_q <= '0; end
            else begin ldir_q <= DirStop; lpwm_q <= '0; end
          end else if (alive_q) begin
            if (kind_q == JobMr) begin
              rdir_q <= v[31] ? DirRev : DirFwd; rpwm_q <= pwm_new;
            end else begin
              ldir_q <= v[31] ? DirRev : DirFwd; lpwm_q <= pwm_new;
            end
          end
          st_q <= StWatch;
        end
        StWatch: begin
          if (wd_val_q != wd_seen_q) begin
            wd_seen_q <= wd_val_q; alive_q <= 1'b1; quiet_q <= '0;
          end else if (quiet_q > timeout_i) begin
            alive_q <= 1'b0;
            rdir_q <= DirStop; rpwm_q <= '0; ldir_q <= DirStop; lpwm_q <= '0;
          end
          if (kind_q == JobBad || kind_q == JobMr || kind_q == JobMl) st_q <= StReply;
          else st_q <= StStatus;
        end
        StReply: begin
          if (out_free) begin
            oreply_q <= 1'b1; olast_q <= 1'b0;
            obyte_q <= rep_byte;
            rcnt_q <= rcnt_q + 4'd1;
            if ((kind_q == JobBad && rcnt_q == 4'd14) ||
                (kind_q != JobBad && rcnt_q == 4'd9)) st_q <= StStatus;
          end
        end
        StStatus: begin
          if (out_free) begin
            oreply_q <= 1'b0; olast_q <= 1'b1; obyte_q <= '0;
            st_q <= StIdle;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o  = ovalid_q;
  assign is_reply_o   = oreply_q;
  assign reply_byte_o = obyte_q;
  assign last_o       = olast_q;
  assign right_dir_o  = ordir_q;
  assign right_pwm_o  = orpwm_q;
  assign left_dir_o   = oldir_q;
  assign left_pwm_o   = olpwm_q;
  assign link_alive_o = oalive_q;
endmodule

// ----- rtl/serial_motor_command_watchdog.sv -----
// ----------------------------------------------------------------------------
// serial_motor_command_watchdog: serial motor commands with a link watchdog
// Collects frames of serial bytes, executes motor and watchdog commands and
// returns reply bytes plus one status word per input word.
// ----------------------------------------------------------------------------
// A plain byte or tick passes the job queue and the Idle, Watch and Status
// states before its status word is registered. A motor or watchdog frame is
// first parsed one buffer byte per cycle; a motor frame then gives replies.
// Reply bytes leave one per cycle while the output is ready; an input word is
// taken only while the back end is idle and the queue is empty, so a frame is
// finished, status word included, before the next input word is taken.
// Reset: asynchronous and active low; the frame buffer is cleared, motors
// stop, the link is dead and the registers return to 500, 155 and 100.
module serial_motor_command_watchdog import smcw_pkg::*; #(
  parameter int unsigned FRAME_DEPTH = FrameDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        is_reply_o,
  output logic [7:0]  reply_byte_o,
  output logic [1:0]  right_dir_o,
  output logic [7:0]  right_pwm_o,
  output logic [1:0]  left_dir_o,
  output logic [7:0]  left_pwm_o,
  output logic        link_alive_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [15:0] timeout_q, center_q;
  logic [7:0]  min_drive_q;
  logic        fq_valid, fq_ready, qb_valid, qb_ready, q_empty, back_busy;
  job_t        fq_job, qb_job;
  logic [FRAME_DEPTH*8-1:0] frame;
  logic [1:0]  reg_idx;

  // Configuration registers. Byte address 4*i holds register i.
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q   <= TimeoutRst;
      center_q    <= CenterRst;
      min_drive_q <= MinDriveRst;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        RegTimeout:  timeout_q   <= pwdata[15:0];
        RegCenter:   center_q    <= pwdata[15:0];
        RegMinDrive: min_drive_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegTimeout:  prdata = {16'd0, timeout_q};
      RegCenter:   prdata = {16'd0, center_q};
      RegMinDrive: prdata = {24'd0, min_drive_q};
      default:     prdata = '0;
    endcase
  end

  // The front end holds off new words while any job is queued or running, so
  // the frame buffer stays fixed while the back end reads it.
  smcw_front #(.FrameDepth(FRAME_DEPTH)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .cmd_i, .rx_byte_i,
    .job_valid_o(fq_valid), .job_ready_i(fq_ready), .job_o(fq_job),
    .busy_i(back_busy || !q_empty), .frame_o(frame)
  );

  smcw_queue u_queue (
    .clk_i, .rst_ni, .wr_valid_i(fq_valid), .wr_ready_o(fq_ready),
    .wr_job_i(fq_job), .rd_valid_o(qb_valid), .rd_ready_i(qb_ready),
    .rd_job_o(qb_job), .empty_o(q_empty)
  );

  smcw_back #(.FrameDepth(FRAME_DEPTH)) u_back (
    .clk_i, .rst_ni, .job_valid_i(qb_valid), .job_ready_o(qb_ready),
    .job_i(qb_job), .frame_i(frame), .timeout_i(timeout_q),
    .center_i(center_q), .min_drive_i(min_drive_q), .busy_o(back_busy),
    .out_valid_o, .out_ready_i, .is_reply_o, .reply_byte_o, .right_dir_o,
    .right_pwm_o, .left_dir_o, .left_pwm_o, .link_alive_o, .last_o
  );

  // A dead link never shows a running motor.
  a_dead_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !link_alive_o |-> right_pwm_o == 8'd0 && left_pwm_o == 8'd0 &&
      right_dir_o == DirStop && left_dir_o == DirStop) else $error("dead link check");
  // Status words carry no reply byte.
  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> !is_reply_o && reply_byte_o == 8'd0)
    else $error("status word carries a reply byte");
  // No input is taken while a job is in flight.
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_busy |-> !in_ready_o) else $error("input accepted while busy");
endmodule
